// ----- sv/sfe_pkg.sv -----
// Shared types and constants for the support foot estimator.
`default_nettype none

package sfe_pkg;

    localparam int SENSORS     = 8;
    localparam int IDX_W       = $clog2(SENSORS);
    localparam int P_W         = 16;               // sensor reading width, Q4.12
    localparam int WT_W        = 15;               // weight width, Q1.14
    localparam int CFG_W       = 16;
    localparam int NORM_W      = 17;               // Q1.16, up to 1.0 inclusive
    localparam int TOT_W       = NORM_W + IDX_W;   // sum of eight normalised values
    localparam int PROD_W      = WT_W + NORM_W;
    localparam int WSUM_W      = PROD_W + IDX_W + 1;
    localparam int DEN_W       = TOT_W;            // divider denominator width
    localparam int QUO_W       = NORM_W;           // divider quotient width
    localparam int LOW_W       = NORM_W;           // dividend bits shifted in
    localparam int NORM_STEPS  = NORM_W;
    localparam int FINAL_STEPS = 16;
    localparam int STEP_W      = $clog2(NORM_STEPS);
    localparam int SIDE_W      = 16;

    localparam logic [NORM_W-1:0] ONE_Q16 = NORM_W'(65536);

    localparam logic [CFG_W-1:0] MAX_PRESSURE_RST = 16'd16384;
    localparam logic [CFG_W-1:0] MIN_PRESSURE_RST = 16'd410;
    localparam logic [WT_W-1:0]  OUTER_WEIGHT_RST = 15'd16384;
    localparam logic [WT_W-1:0]  INNER_WEIGHT_RST = 15'd8192;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_PRESSURE = 2'd0,
        CFG_MIN_PRESSURE = 2'd1,
        CFG_OUTER_WEIGHT = 2'd2,
        CFG_INNER_WEIGHT = 2'd3
    } cfg_idx_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             capture;     // latch an input beat, clear sums
        logic             load_norm;   // clamp, update peak, start a normalising divide
        logic             div_step;    // one restoring division step
        logic             take_norm;   // keep the normalised value
        logic             mul;         // weight times normalised value
        logic             add;         // accumulate total and weighted sum
        logic             load_final;  // start the weighted sum / total divide
        logic             publish;     // write result and previous side
        logic [IDX_W-1:0] idx;         // sensor being worked on
    } sfe_cmd_t;

endpackage

`default_nettype wire

// ----- sv/sfe_ctrl.sv -----
// Controller: sequences the eight normalising divides and the final divide.
`default_nettype none

module sfe_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output sfe_pkg::sfe_cmd_t      cmd
);
    import sfe_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_LOAD  = 9'b000000010,
        ST_DIV   = 9'b000000100,
        ST_TAKE  = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_ADD   = 9'b000100000,
        ST_FLOAD = 9'b001000000,
        ST_FDIV  = 9'b010000000,
        ST_FIN   = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_norm = 1'b1;
                step_next     = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(NORM_STEPS - 1)) begin
                    state_next = ST_TAKE;
                end
            end
            ST_TAKE: begin
                cmd.take_norm = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add = 1'b1;
                if (idx_reg == IDX_W'(SENSORS - 1)) begin
                    state_next = ST_FLOAD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_FLOAD: begin
                cmd.load_final = 1'b1;
                step_next      = '0;
                state_next     = ST_FDIV;
            end
            ST_FDIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(FINAL_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold the result until the output register is free
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid: set on publish, drop once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.publish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // no second beat is taken while one is in work
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // a result is never written over one still waiting
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten");

    // the final divide starts only after the last sensor
    a_final_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_final |-> (idx_reg == IDX_W'(SENSORS - 1)))
        else $error("final divide started early");
`endif

endmodule

`default_nettype wire

// ----- sv/sfe_dp.sv -----
// Datapath: config, peaks, shared serial divider, multiplier and accumulators.
`default_nettype none

module sfe_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire sfe_pkg::sfe_cmd_t            cmd,
    input  wire logic [sfe_pkg::SENSORS*sfe_pkg::P_W-1:0] s_tdata,
    input  wire logic                         cfg_wr_en,
    input  wire logic [1:0]                   cfg_addr,
    input  wire logic [sfe_pkg::CFG_W-1:0]    cfg_wdata,
    output logic signed [sfe_pkg::SIDE_W-1:0] support_side,
    output logic                              support_changed
);
    import sfe_pkg::*;

    // configuration
    logic [P_W-1:0]  max_pressure_reg;
    logic [P_W-1:0]  min_pressure_reg;
    logic [WT_W-1:0] outer_weight_reg;
    logic [WT_W-1:0] inner_weight_reg;

    // per-sensor state
    logic [P_W-1:0] sample_reg [SENSORS];
    logic [P_W-1:0] peak_reg   [SENSORS];

    // divider
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [LOW_W-1:0] low_reg, low_next;
    logic [QUO_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_diff;
    logic             trial_ge;
    logic             peak_zero_reg;

    // accumulation
    logic [NORM_W-1:0]        norm_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [TOT_W-1:0]         total_reg;
    logic signed [WSUM_W-1:0] wsum_reg;
    logic                     neg_reg;

    // result
    logic signed [SIDE_W-1:0] side_reg;
    logic                     changed_reg;
    logic signed [SIDE_W-1:0] prev_side_reg;
    logic signed [SIDE_W-1:0] side_calc;

    // sensor under work
    logic [P_W-1:0]   cur_sample;
    logic [P_W-1:0]   cur_peak;
    logic [P_W-1:0]   clamped;
    logic [P_W-1:0]   new_peak;
    logic [WT_W-1:0]  cur_weight;
    logic [WSUM_W-1:0] wsum_mag;

    assign cur_sample = sample_reg[cmd.idx];
    assign cur_peak   = peak_reg[cmd.idx];
    assign clamped    = (cur_sample > max_pressure_reg) ? max_pressure_reg : cur_sample;
    assign new_peak   = (clamped > cur_peak) ? clamped : cur_peak;
    // outer sensors are 0, 2, 5 and 7; right foot (upper four) subtracts
    assign cur_weight = (cmd.idx[0] == cmd.idx[IDX_W-1]) ? outer_weight_reg
                                                          : inner_weight_reg;
    assign wsum_mag   = wsum_reg[WSUM_W-1] ? WSUM_W'(-wsum_reg) : WSUM_W'(wsum_reg);

    // Restoring division step
    assign trial      = {rem_reg, low_reg[LOW_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign trial_ge   = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        if (cmd.load_norm) begin
            // dividend is clamped << 16; its top bits start the remainder
            rem_next  = DEN_W'(clamped[P_W-1:1]);
            low_next  = {clamped[0], 16'd0};
            quot_next = '0;
        end else if (cmd.load_final) begin
            rem_next  = wsum_mag[FINAL_STEPS +: DEN_W];
            low_next  = {wsum_mag[FINAL_STEPS-1:0], 1'b0};
            quot_next = '0;
        end else if (cmd.div_step) begin
            rem_next  = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next  = {low_reg[LOW_W-2:0], 1'b0};
            quot_next = {quot_reg[QUO_W-2:0], trial_ge};
        end
    end

    // Saturate the final quotient with its sign; zero total gives zero
    always_comb begin
        if (total_reg == '0) begin
            side_calc = '0;
        end else if (!neg_reg) begin
            side_calc = (quot_reg > QUO_W'(32767)) ? 16'sh7FFF : SIDE_W'(quot_reg);
        end else begin
            side_calc = (quot_reg > QUO_W'(32768)) ? 16'sh8000 : SIDE_W'(-quot_reg);
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pressure_reg <= MAX_PRESSURE_RST;
            min_pressure_reg <= MIN_PRESSURE_RST;
            outer_weight_reg <= OUTER_WEIGHT_RST;
            inner_weight_reg <= INNER_WEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MAX_PRESSURE: max_pressure_reg <= cfg_wdata;
                CFG_MIN_PRESSURE: min_pressure_reg <= cfg_wdata;
                CFG_OUTER_WEIGHT: outer_weight_reg <= cfg_wdata[WT_W-1:0];
                CFG_INNER_WEIGHT: inner_weight_reg <= cfg_wdata[WT_W-1:0];
                default: ;
            endcase
        end
    end

    // Peak registers: reload on reset and on a min_pressure write, else grow
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SENSORS; i++) begin
                peak_reg[i] <= MIN_PRESSURE_RST;
            end
        end else if (cfg_wr_en && (cfg_idx_t'(cfg_addr) == CFG_MIN_PRESSURE)) begin
            for (int i = 0; i < SENSORS; i++) begin
                peak_reg[i] <= cfg_wdata;
            end
        end else if (cmd.load_norm) begin
            peak_reg[cmd.idx] <= new_peak;
        end
    end

    // Input sample capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int i = 0; i < SENSORS; i++) begin
                sample_reg[i] <= s_tdata[i*P_W +: P_W];
            end
        end
    end

    // Divider and accumulators
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        if (cmd.load_norm) begin
            den_reg       <= DEN_W'(new_peak);
            peak_zero_reg <= (new_peak == '0);
        end
        if (cmd.load_final) begin
            den_reg <= total_reg;
            neg_reg <= wsum_reg[WSUM_W-1];
        end
        if (cmd.take_norm) begin
            norm_reg <= peak_zero_reg ? '0 : quot_reg;
        end
        if (cmd.mul) begin
            prod_reg <= cur_weight * norm_reg;
        end
        if (cmd.capture) begin
            total_reg <= '0;
            wsum_reg  <= '0;
        end else if (cmd.add) begin
            total_reg <= total_reg + TOT_W'(norm_reg);
            if (cmd.idx[IDX_W-1]) begin
                wsum_reg <= wsum_reg - $signed({{(WSUM_W-PROD_W){1'b0}}, prod_reg});
            end else begin
                wsum_reg <= wsum_reg + $signed({{(WSUM_W-PROD_W){1'b0}}, prod_reg});
            end
        end
    end

    // Result and previous side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_side_reg <= '0;
        end else if (cmd.publish) begin
            prev_side_reg <= side_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            side_reg    <= side_calc;
            changed_reg <= ((prev_side_reg > 0) && (side_calc < 0)) ||
                           ((prev_side_reg < 0) && (side_calc > 0));
        end
    end

    assign support_side    = side_reg;
    assign support_changed = changed_reg;

`ifndef NO_ASSERTIONS
    logic peaks_floor_ok;
    always_comb begin
        peaks_floor_ok = 1'b1;
        for (int i = 0; i < SENSORS; i++) begin
            if (peak_reg[i] < min_pressure_reg) begin
                peaks_floor_ok = 1'b0;
            end
        end
    end

    // peaks never drop below the minimum pressure
    a_peak_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        peaks_floor_ok)
        else $error("peak below min_pressure");

    // the partial remainder stays below the divisor while dividing
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && (den_reg != '0)) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    // a normalised value never exceeds one
    a_norm_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> (norm_reg <= ONE_Q16))
        else $error("normalised value above one");
`endif

endmodule

`default_nettype wire

// ----- sv/support_foot_estimator_core.sv -----
// Top level of the support foot estimator: controller plus datapath.
//
//  Channel  | Ports                          | Beat content
//  ---------+--------------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tdata      | eight 16-bit pressure readings
//  result   | m_tvalid m_tready m_tdata      | support side, support changed
//  config   | cfg_wr_en cfg_addr cfg_wdata   | one register write per cycle
//
//  The result follows eight normalising divides of 17 steps, each with a load,
//  take, multiply and add, then a 16-step final divide with its load and
//  publish, all on one shared restoring divider. A new beat is taken only
//  once the result is published. The output register lets the next beat be
//  accepted while a result waits. A result not taken stalls the block only
//  at its final write. Reset is synchronous and needs no clearing pass.
`default_nettype none

module support_foot_estimator_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // left_toe_outer, left_toe_inner, left_heel_outer, left_heel_inner,
    // right_toe_inner, right_toe_outer, right_heel_inner, right_heel_outer
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // support_side [15:0], support_changed [16], zero fill [23:17]
    output logic [23:0]       m_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata
);
    import sfe_pkg::*;

    sfe_cmd_t                 cmd;
    logic signed [SIDE_W-1:0] support_side;
    logic                     support_changed;

    sfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sfe_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_tdata         (s_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .support_side    (support_side),
        .support_changed (support_changed)
    );

    // Pack the result beat
    assign m_tdata = {7'd0, support_changed, support_side};

endmodule

`default_nettype wire

// ----- dv/support_foot_estimator_core_test.sv -----
// Self-checking testbench for the support foot estimator core.
`timescale 1ns / 1ps

module support_foot_estimator_core_test;
    import sfe_pkg::*;

    typedef struct {
        logic signed [SIDE_W-1:0] side;
        logic                     changed;
    } balance_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // left_toe_outer, left_toe_inner, left_heel_outer, left_heel_inner,
    // right_toe_inner, right_toe_outer, right_heel_inner, right_heel_outer
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // support_side [15:0], support_changed [16], zero fill [23:17]
    logic [23:0]  m_tdata;
    logic         cfg_wr_en;
    logic [1:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    // Shadow of the block's registers and state
    logic [P_W-1:0]    max_p_r;
    logic [P_W-1:0]    min_p_r;
    logic [WT_W-1:0]   outer_w_r;
    logic [WT_W-1:0]   inner_w_r;
    logic [P_W-1:0]    peak_r [SENSORS];
    logic signed [SIDE_W-1:0] last_side_r;

    balance_t balance_q [$];
    int       mismatch_count = 0;
    bit       tx_steady = 1'b0;
    bit       rx_steady = 1'b0;

    support_foot_estimator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Work out the balance for one accepted sample and queue it
    function automatic void predict_balance(input logic [127:0] smp);
        logic [P_W-1:0] p;
        longint norm;
        longint total;
        longint weighted;
        longint side;
        longint wt;
        balance_t bal;
        int i;
        total = 0;
        weighted = 0;
        for (i = 0; i < SENSORS; i++) begin
            p = smp[16*i +: 16];
            if (p > max_p_r)
                p = max_p_r;
            if (p > peak_r[i])
                peak_r[i] = p;
            norm = 0;
            if (peak_r[i] != 0) begin
                norm = (longint'(p) << 16) / longint'(peak_r[i]);
                if (norm > 65536)
                    norm = 65536;
            end
            case (i)
                0, 2:    wt = longint'(outer_w_r);
                1, 3:    wt = longint'(inner_w_r);
                4, 6:    wt = -longint'(inner_w_r);
                default: wt = -longint'(outer_w_r);
            endcase
            total += norm;
            weighted += wt * norm;
        end
        side = 0;
        bal.changed = 1'b0;
        if (total != 0) begin
            side = weighted / total;
            if (side > 32767)
                side = 32767;
            if (side < -32768)
                side = -32768;
            bal.changed = (last_side_r > 0 && side < 0) || (last_side_r < 0 && side > 0);
        end
        bal.side = SIDE_W'(side);
        last_side_r = bal.side;
        balance_q.push_back(bal);
    endfunction

    // Gap before a beat: mostly short, a few long enough to cover a whole beat
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(20, 250);
    endfunction

    // Send one sample beat and predict its result on acceptance
    task automatic send_sample(input logic [127:0] smp);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_balance(smp);
    endtask

    // Drop valid and hold until every expected result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (balance_q.size() != 0) @(posedge aclk);
    endtask

    // Write one register, only while the block is idle
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        int i;
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MAX_PRESSURE: max_p_r = val;
            CFG_MIN_PRESSURE: begin
                min_p_r = val;
                for (i = 0; i < SENSORS; i++)
                    peak_r[i] = val;
            end
            CFG_OUTER_WEIGHT: outer_w_r = val[WT_W-1:0];
            CFG_INNER_WEIGHT: inner_w_r = val[WT_W-1:0];
            default: ;
        endcase
    endtask

    // Build a random sample, shaped to reach clamping, one-sided and quiet cases
    function automatic logic [127:0] make_sample();
        logic [127:0] smp;
        int shape;
        int i;
        int hot;
        smp = '0;
        shape = $urandom_range(0, 9);
        hot = $urandom_range(0, SENSORS - 1);
        for (i = 0; i < SENSORS; i++) begin
            case (shape)
                0, 1, 2: smp[16*i +: 16] = 16'($urandom_range(0, 65535));
                3, 4, 5: smp[16*i +: 16] = 16'($urandom_range(0, int'(max_p_r)));
                6:       smp[16*i +: 16] = (i < 4) ? 16'($urandom_range(0, 65535)) : 16'd0;
                7:       smp[16*i +: 16] = (i >= 4) ? 16'($urandom_range(0, 65535)) : 16'd0;
                8:       smp[16*i +: 16] = (i == hot) ? 16'($urandom_range(0, 65535)) : 16'd0;
                default: smp[16*i +: 16] = 16'($urandom_range(0, 64));
            endcase
            if (shape <= 5 && $urandom_range(0, 9) == 0)
                smp[16*i +: 16] = 16'd0;
        end
        return smp;
    endfunction

    // Pick a random register setting, extremes included
    task automatic write_random_config();
        logic [15:0] val;
        case ($urandom_range(0, 4))
            0:       val = 16'hFFFF;
            1:       val = 16'd16384;
            2:       val = 16'($urandom_range(1, 65535));
            3:       val = 16'($urandom_range(1, 255));
            default: val = 16'($urandom_range(4096, 32768));
        endcase
        write_reg(CFG_MAX_PRESSURE, val);
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 4))
                0:       val = 16'd1;
                1:       val = 16'd410;
                2:       val = 16'($urandom_range(1, 65535));
                3:       val = 16'hFFFF;
                default: val = 16'($urandom_range(1, 2000));
            endcase
            write_reg(CFG_MIN_PRESSURE, val);
        end
        case ($urandom_range(0, 3))
            0:       val = 16'd0;
            1:       val = 16'd32767;
            2:       val = 16'($urandom_range(0, 65535));
            default: val = 16'($urandom_range(0, 32767));
        endcase
        write_reg(CFG_OUTER_WEIGHT, val);
        case ($urandom_range(0, 3))
            0:       val = 16'd0;
            1:       val = 16'd32767;
            2:       val = 16'($urandom_range(0, 65535));
            default: val = 16'($urandom_range(0, 32767));
        endcase
        write_reg(CFG_INNER_WEIGHT, val);
    endtask

    // Reset settings: zero total, full clamp, one foot then the other
    task automatic test_reset_defaults();
        send_sample(128'd0);
        send_sample({8{16'hFFFF}});
        send_sample({64'd0, {4{16'hFFFF}}});
        send_sample({{4{16'hFFFF}}, 64'd0});
        send_sample({64'd0, {4{16'h2000}}});
        send_sample({112'd0, 16'd1});
    endtask

    // Widest clamp and peak floor, weights with the ignored top bit set
    task automatic test_register_extremes();
        drain_results();
        write_reg(CFG_MAX_PRESSURE, 16'hFFFF);
        write_reg(CFG_MIN_PRESSURE, 16'hFFFF);
        write_reg(CFG_OUTER_WEIGHT, 16'hFFFF);
        write_reg(CFG_INNER_WEIGHT, 16'h8000);
        send_sample({8{16'hFFFF}});
        send_sample({112'd0, 16'hFFFF});
        send_sample({16'hFFFF, 112'd0});
        send_sample({8{16'd1}});
    endtask

    // Clamp of zero forces a zero total whatever the readings
    task automatic test_zero_clamp();
        drain_results();
        write_reg(CFG_MAX_PRESSURE, 16'd0);
        send_sample({8{16'hFFFF}});
        send_sample(make_sample());
    endtask

    // Peak floor of zero: a sensor's value stays zero until it sees pressure
    task automatic test_zero_peak();
        drain_results();
        write_reg(CFG_MAX_PRESSURE, 16'hFFFF);
        write_reg(CFG_MIN_PRESSURE, 16'd0);
        write_reg(CFG_OUTER_WEIGHT, 16'd1);
        write_reg(CFG_INNER_WEIGHT, 16'd32767);
        send_sample(128'd0);
        send_sample({112'd0, 16'd100});
        send_sample({16'd5, 112'd0});
        send_sample({48'd0, 16'hFFFF, 48'd0, 16'd50});
    endtask

    // Random phases, each with its own setting and handshake pressure
    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 12; phase++) begin
            drain_results();
            write_random_config();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 150; n++) begin
                if (n == 75 && $urandom_range(0, 2) == 0)
                    drain_results();
                send_sample(make_sample());
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Result side: random stalls, mostly short, a few long
    initial begin
        int r;
        int rx_hold;
        rx_hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
            end else if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_tready <= 1'b1;
                    rx_hold = $urandom_range(0, 5);
                end else if (r < 92) begin
                    m_tready <= 1'b0;
                    rx_hold = $urandom_range(0, 3);
                end else begin
                    m_tready <= 1'b0;
                    rx_hold = $urandom_range(20, 300);
                end
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        balance_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (balance_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 100)
                    $display("%0t: result beat with none expected, got %h", $time, m_tdata);
            end else begin
                want = balance_q.pop_front();
                if (m_tdata[15:0] !== want.side) begin
                    mismatch_count++;
                    if (mismatch_count <= 100)
                        $display("%0t: support_side expected %0d got %0d", $time,
                                 want.side, $signed(m_tdata[15:0]));
                end
                if (m_tdata[16] !== want.changed) begin
                    mismatch_count++;
                    if (mismatch_count <= 100)
                        $display("%0t: support_changed expected %0b got %0b", $time,
                                 want.changed, m_tdata[16]);
                end
                if (m_tdata[23:17] !== 7'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 100)
                        $display("%0t: zero fill expected 0 got %h", $time, m_tdata[23:17]);
                end
            end
        end
    end

    // Hard stop well past the slowest legal run
    initial begin
        #12000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int i;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_MAX_PRESSURE;
        cfg_wdata = '0;
        max_p_r   = MAX_PRESSURE_RST;
        min_p_r   = MIN_PRESSURE_RST;
        outer_w_r = OUTER_WEIGHT_RST;
        inner_w_r = INNER_WEIGHT_RST;
        for (i = 0; i < SENSORS; i++)
            peak_r[i] = MIN_PRESSURE_RST;
        last_side_r = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_zero_clamp();
        test_zero_peak();
        test_random_traffic();

        // Settle: every result in, then allow one beat's latency for strays
        drain_results();
        repeat (400) @(posedge aclk);
        if (mismatch_count == 0 && balance_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
